// ----- design/wsdf_pkg.sv -----
// Shared definitions for the WebSocket frame deframer with unmasking.
// Holds the byte width and the length-byte field masks; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package wsdf_pkg;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 7;
    localparam int unsigned KEY_N  = 4;
    localparam int unsigned KPOS_W = 2;

    localparam logic [BYTE_W-1:0] LEN_MASK = 8'o177;
    localparam logic [BYTE_W-1:0] MASK_BIT = 8'o200;
endpackage
`default_nettype wire

// ----- design/websocket_frame_deframer_unmask_top.sv -----
// WebSocket frame deframer: parses frame headers and unmasks payload bytes.
// Uses wsdf_pkg for widths and length-byte masks.
`timescale 1ns / 1ps
`default_nettype none
// The block takes one received byte per cycle while o_stall is low.
// It skips the flags byte, reads the mask bit and the 7-bit length, captures
// four key bytes when the frame is masked, and then sends each payload byte
// XORed with the key byte in turn (unchanged when unmasked), with
// o_frame_last high on the final byte. Length codes 126 and 127 are plain
// lengths, and a zero-length frame gives no item. Each byte passes through
// one clocked stage, so a result appears in the cycle after its byte is taken;
// the result register is the only buffer, and o_stall rises only while a
// result is held and the output is stalled.
module websocket_frame_deframer_unmask_top (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic [wsdf_pkg::BYTE_W-1:0] i_rx_byte,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic [wsdf_pkg::BYTE_W-1:0]     o_payload_byte,
    output logic                            o_frame_last
);
    typedef enum logic [2:0] {
        PH_FLAGS   = 3'd0,
        PH_LENGTH  = 3'd1,
        PH_KEY0    = 3'd2,
        PH_KEY1    = 3'd3,
        PH_KEY2    = 3'd4,
        PH_KEY3    = 3'd5,
        PH_PAYLOAD = 3'd6
    } t_phase;

    t_phase                           r_phase;
    logic [wsdf_pkg::LEN_W-1:0]       r_bytes_left;
    logic [wsdf_pkg::BYTE_W-1:0]      r_mask_key [wsdf_pkg::KEY_N];
    logic [wsdf_pkg::KPOS_W-1:0]      r_key_pos;
    logic                             r_masked;
    logic                             r_out_valid;
    logic [wsdf_pkg::BYTE_W-1:0]      r_payload_byte;
    logic                             r_frame_last;

    logic                             w_acc;
    logic                             w_last;
    logic [wsdf_pkg::BYTE_W-1:0]      w_key;
    logic [wsdf_pkg::KPOS_W-1:0]      w_key_idx;
    logic [wsdf_pkg::LEN_W-1:0]       w_len;

    assign o_stall        = r_out_valid && i_stall;
    assign w_acc          = i_valid && !o_stall;
    assign o_valid        = r_out_valid;
    assign o_payload_byte = r_payload_byte;
    assign o_frame_last   = r_frame_last;

    assign w_last    = (r_bytes_left <= wsdf_pkg::LEN_W'(1));
    assign w_key     = r_masked ? r_mask_key[r_key_pos] : '0;
    assign w_key_idx = wsdf_pkg::KPOS_W'(r_phase - PH_KEY0);
    assign w_len     = wsdf_pkg::LEN_W'(i_rx_byte & wsdf_pkg::LEN_MASK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_FLAGS;
            r_bytes_left <= '0;
            r_key_pos    <= '0;
            r_masked     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_acc) begin
                case (r_phase)
                    PH_LENGTH: begin
                        r_bytes_left <= w_len;
                        r_masked     <= (i_rx_byte & wsdf_pkg::MASK_BIT) != '0;
                        r_key_pos    <= '0;
                        if ((i_rx_byte & wsdf_pkg::MASK_BIT) != '0) begin
                            r_phase <= PH_KEY0;
                        end else if (w_len != '0) begin
                            r_phase <= PH_PAYLOAD;
                        end else begin
                            r_phase <= PH_FLAGS;
                        end
                    end
                    PH_KEY0, PH_KEY1, PH_KEY2, PH_KEY3: begin
                        r_mask_key[w_key_idx] <= i_rx_byte;
                        if (r_phase == PH_KEY3) begin
                            r_phase <= (r_bytes_left != '0) ? PH_PAYLOAD : PH_FLAGS;
                        end else begin
                            r_phase <= t_phase'(r_phase + 3'd1);
                        end
                    end
                    PH_PAYLOAD: begin
                        r_out_valid    <= 1'b1;
                        r_payload_byte <= i_rx_byte ^ w_key;
                        r_frame_last   <= w_last;
                        r_key_pos      <= r_key_pos + wsdf_pkg::KPOS_W'(1);
                        if (w_last) begin
                            r_bytes_left <= '0;
                            r_phase      <= PH_FLAGS;
                        end else begin
                            r_bytes_left <= r_bytes_left - wsdf_pkg::LEN_W'(1);
                        end
                    end
                    default: begin
                        r_phase <= PH_LENGTH;
                    end
                endcase
            end
        end
    end

    a_payload_gives_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && r_phase == PH_PAYLOAD) |=> r_out_valid)
        else $error("payload byte accepted without a result");

    a_header_gives_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && r_phase != PH_PAYLOAD && !i_stall) |=> !r_out_valid)
        else $error("header byte produced a result");

    a_payload_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_bytes_left != '0))
        else $error("payload phase with no bytes left");

    a_last_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && r_phase == PH_PAYLOAD && w_last) |=>
        (r_phase == PH_FLAGS && r_frame_last))
        else $error("final payload byte did not end the frame");
endmodule
`default_nettype wire
